>>> hdl/ffpa_pkg.sv
package ffpa_pkg;

  // Default sizing of the pool and of the descriptor table
  localparam int unsigned POOL_BYTES_DEF  = 65536;
  localparam int unsigned DESCRIPTORS_DEF = 2048;

  // Request codes
  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_SESS  = 2'd2;
  localparam logic [1:0] ACT_QUERY = 2'd3;

  // Descriptor flag bits
  localparam int unsigned F_ACTIVE  = 0;
  localparam int unsigned F_USED    = 1;
  localparam int unsigned F_PERSIST = 2;

  localparam logic [2:0] FLAGS_NONE   = 3'b000;
  localparam logic [2:0] FLAGS_ACTIVE = 3'b001;
  localparam logic [2:0] FLAGS_USED   = 3'b011;
  localparam logic [2:0] FLAGS_PERS   = 3'b111;

  typedef struct packed {
    logic [1:0]  action;
    logic [16:0] req_size;
    logic        persistent;
    logic [15:0] free_offset;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [15:0] alloc_offset;
    logic [31:0] alloc_id;
    logic [16:0] bytes_held;
    logic [16:0] largest_free;
    logic [11:0] free_segments;
    logic [11:0] active_allocs;
    logic [16:0] session_bytes_held;
    logic [31:0] total_allocs;
    logic [31:0] total_frees;
    logic [31:0] session_allocs;
    logic [31:0] session_frees;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC_WALK,
    ST_SPARE_SCAN,
    ST_ALLOC_TAKE,
    ST_FREE_WALK,
    ST_SESS_WALK,
    ST_MERGE_START,
    ST_MERGE_CUR,
    ST_MERGE_NX,
    ST_MERGE_FIN,
    ST_STATS_START,
    ST_STATS_WALK,
    ST_DONE
  } state_t;

  // Accumulator control from the sequencer
  typedef struct packed {
    logic clr;
    logic en;
  } stats_ctl_t;

endpackage

>>> hdl/first_fit_pool_allocator.sv
// First-fit pool allocator with coalescing.
// Input channel (in_valid/in_ready/in_data) takes one request at a time:
// allocate, free, session reset or query. The result channel
// (out_valid/out_ready/out_data) returns one result per request with status,
// the new offset and id for an allocation, and usage statistics.
// Segment descriptors live in one single-port-read, single-port-write memory
// of DESCRIPTORS words; the work walks the segment chain one descriptor per
// cycle, and a split also scans the table for a spare descriptor. After
// reset a clearing pass writes every descriptor with in_ready low; the
// counters restart and next id is one.
// The result sits in an output register; the next request is accepted while
// it waits, and only the hand-over of its own result waits on out_ready.
module first_fit_pool_allocator #(
  parameter int unsigned POOL_BYTES  = ffpa_pkg::POOL_BYTES_DEF,
  parameter int unsigned DESCRIPTORS = ffpa_pkg::DESCRIPTORS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffpa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ffpa_pkg::out_item_t out_data
);
  import ffpa_pkg::*;

  localparam int unsigned AW = $clog2(DESCRIPTORS);
  localparam int unsigned DW = $clog2(POOL_BYTES) + $clog2(POOL_BYTES + 1) + 3 + 32
                               + $clog2(DESCRIPTORS + 1);

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, mem_rdata;

  ffpa_desc_mem #(.DEPTH(DESCRIPTORS), .WIDTH(DW), .AW(AW)) u_mem (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_en  (mem_re),
    .rd_addr(mem_raddr),
    .rd_data(mem_rdata)
  );

  ffpa_ctrl #(
    .POOL_BYTES (POOL_BYTES),
    .DESCRIPTORS(DESCRIPTORS),
    .AW         (AW),
    .DW         (DW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

`ifndef SYNTHESIS
  // One request in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  // Clearing pass keeps the input closed right after reset
  a_clear_closed: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open during clearing pass");

  // A waiting result is not overwritten
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("pending result lost");

  // Failures carry no offset and no id
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.alloc_id == 32'd0 &&
                                     out_data.alloc_offset == 16'd0)
    else $error("failed result carries an allocation");
`endif

endmodule

>>> hdl/ffpa_desc_mem.sv
module ffpa_desc_mem #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned WIDTH = 80,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/ffpa_stats.sv
module ffpa_stats #(
  parameter int unsigned LW = 17,
  parameter int unsigned IW = 12
) (
  input  logic    clk,
  input  ffpa_pkg::stats_ctl_t ctl,
  input  logic    seg_used,
  input  logic    seg_persist,
  input  logic [LW-1:0] seg_len,
  output logic [LW-1:0] held_bytes,
  output logic [LW-1:0] sess_bytes,
  output logic [LW-1:0] largest,
  output logic [IW-1:0] nfree,
  output logic [IW-1:0] nused
);
  import ffpa_pkg::*;

  logic [LW-1:0] used_r, used_nxt, sess_r, sess_nxt, big_r, big_nxt;
  logic [IW-1:0] nfree_r, nfree_nxt, nused_r, nused_nxt;

  // Per-segment accumulation along the chain
  always_comb begin
    used_nxt  = used_r;
    sess_nxt  = sess_r;
    big_nxt   = big_r;
    nfree_nxt = nfree_r;
    nused_nxt = nused_r;
    if (ctl.clr) begin
      used_nxt  = '0;
      sess_nxt  = '0;
      big_nxt   = '0;
      nfree_nxt = '0;
      nused_nxt = '0;
    end else if (ctl.en) begin
      if (seg_used) begin
        used_nxt  = used_r + seg_len;
        nused_nxt = nused_r + IW'(1);
        if (!seg_persist) begin
          sess_nxt = sess_r + seg_len;
        end
      end else begin
        nfree_nxt = nfree_r + IW'(1);
        if (seg_len > big_r) begin
          big_nxt = seg_len;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    used_r  <= used_nxt;
    sess_r  <= sess_nxt;
    big_r   <= big_nxt;
    nfree_r <= nfree_nxt;
    nused_r <= nused_nxt;
  end

  assign held_bytes = used_r;
  assign sess_bytes = sess_r;
  assign largest    = big_r;
  assign nfree      = nfree_r;
  assign nused      = nused_r;

endmodule

>>> hdl/ffpa_ctrl.sv
module ffpa_ctrl #(
  parameter int unsigned POOL_BYTES  = 65536,
  parameter int unsigned DESCRIPTORS = 2048,
  parameter int unsigned AW          = $clog2(DESCRIPTORS),
  parameter int unsigned DW          = 80
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  ffpa_pkg::in_item_t  in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output ffpa_pkg::out_item_t out_data,
  output logic    mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [DW-1:0] mem_wdata,
  output logic    mem_re,
  output logic [AW-1:0] mem_raddr,
  input  logic [DW-1:0] mem_rdata
);
  import ffpa_pkg::*;

  localparam int unsigned LW = $clog2(POOL_BYTES + 1);
  localparam int unsigned SW = $clog2(POOL_BYTES);
  localparam int unsigned IW = $clog2(DESCRIPTORS + 1);
  localparam int unsigned CW = (LW > 17) ? LW : 17;
  localparam int unsigned OW = (SW > 16) ? SW : 16;
  localparam logic [IW-1:0] NIL  = IW'(DESCRIPTORS);
  localparam logic [AW-1:0] LAST = AW'(DESCRIPTORS - 1);
  localparam logic [LW-1:0] POOL = LW'(POOL_BYTES);

  // Descriptor word: {start, length, flags, id, link}
  function automatic logic [DW-1:0] pack(input logic [SW-1:0] s, input logic [LW-1:0] l,
                                         input logic [2:0] f, input logic [31:0] i,
                                         input logic [IW-1:0] k);
    pack = {s, l, f, i, k};
  endfunction

  logic [SW-1:0] r_start;
  logic [LW-1:0] r_len;
  logic [2:0]    r_flags;
  logic [31:0]   r_id;
  logic [IW-1:0] r_link;
  logic          r_nil;

  assign {r_start, r_len, r_flags, r_id, r_link} = mem_rdata;
  assign r_nil = (r_link == NIL);

  state_t        state_r, state_nxt;
  logic [AW-1:0] cur_r, cur_nxt, nx_r, nx_nxt, scan_r, scan_nxt, clr_r, clr_nxt;
  logic [IW-1:0] take_link_r, take_link_nxt;
  logic [SW-1:0] h_start_r, h_start_nxt;
  logic [LW-1:0] h_len_r, h_len_nxt;
  logic [2:0]    h_flags_r, h_flags_nxt;
  logic [31:0]   h_id_r, h_id_nxt;
  logic [IW-1:0] h_link_r, h_link_nxt;
  in_item_t      req_r, req_nxt;
  logic          ok_r, ok_nxt;
  logic [SW-1:0] off_r, off_nxt;
  logic [31:0]   id_r, id_nxt;
  logic [31:0]   next_id_r, next_id_nxt;
  logic [31:0]   cnt_alloc_r, cnt_alloc_nxt, cnt_free_r, cnt_free_nxt;
  logic [31:0]   cnt_salloc_r, cnt_salloc_nxt, cnt_sfree_r, cnt_sfree_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  stats_ctl_t    st_ctl;
  logic [LW-1:0] st_used, st_sess, st_big;
  logic [IW-1:0] st_nfree, st_nused;

  logic [CW-1:0] size_c, len_c;
  logic [LW-1:0] size_l;
  logic          fits, split, off_hit;
  logic [2:0]    take_flags;

  assign size_c     = CW'(req_r.req_size);
  assign len_c      = CW'(r_len);
  assign size_l     = LW'(req_r.req_size);
  assign fits       = !r_flags[F_USED] && (len_c >= size_c);
  assign split      = len_c > size_c;
  assign off_hit    = r_flags[F_USED] && (OW'(r_start) == OW'(req_r.free_offset));
  assign take_flags = req_r.persistent ? FLAGS_PERS : FLAGS_USED;

  ffpa_stats #(.LW(LW), .IW(IW)) u_stats (
    .clk        (clk),
    .ctl        (st_ctl),
    .seg_used   (r_flags[F_USED]),
    .seg_persist(r_flags[F_PERSIST]),
    .seg_len    (r_len),
    .held_bytes (st_used),
    .sess_bytes (st_sess),
    .largest    (st_big),
    .nfree      (st_nfree),
    .nused      (st_nused)
  );

  // Sequencer: every walk state sees the descriptor read in the cycle before
  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    nx_nxt         = nx_r;
    scan_nxt       = scan_r;
    clr_nxt        = clr_r;
    take_link_nxt  = take_link_r;
    h_start_nxt    = h_start_r;
    h_len_nxt      = h_len_r;
    h_flags_nxt    = h_flags_r;
    h_id_nxt       = h_id_r;
    h_link_nxt     = h_link_r;
    req_nxt        = req_r;
    ok_nxt         = ok_r;
    off_nxt        = off_r;
    id_nxt         = id_r;
    next_id_nxt    = next_id_r;
    cnt_alloc_nxt  = cnt_alloc_r;
    cnt_free_nxt   = cnt_free_r;
    cnt_salloc_nxt = cnt_salloc_r;
    cnt_sfree_nxt  = cnt_sfree_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    mem_we         = 1'b0;
    mem_waddr      = cur_r;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    st_ctl         = '0;
    in_ready       = 1'b0;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // Sweep the table to its reset contents
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = (clr_r == '0) ? pack('0, POOL, FLAGS_ACTIVE, '0, NIL)
                                  : pack('0, '0, FLAGS_NONE, '0, NIL);
        if (clr_r == LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt   = in_data;
          ok_nxt    = 1'b1;
          off_nxt   = '0;
          id_nxt    = '0;
          mem_re    = 1'b1;
          mem_raddr = '0;
          cur_nxt   = '0;
          case (in_data.action)
            ACT_ALLOC: begin
              if (in_data.req_size == '0) begin
                ok_nxt    = 1'b0;
                state_nxt = ST_STATS_START;
              end else begin
                state_nxt = ST_ALLOC_WALK;
              end
            end
            ACT_FREE:  state_nxt = ST_FREE_WALK;
            ACT_SESS:  state_nxt = ST_SESS_WALK;
            default:   state_nxt = ST_STATS_START;
          endcase
        end
      end

      // First-fit search along the chain
      ST_ALLOC_WALK: begin
        if (fits) begin
          h_start_nxt = r_start;
          h_len_nxt   = r_len;
          h_link_nxt  = r_link;
          if (split) begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            scan_nxt  = '0;
            state_nxt = ST_SPARE_SCAN;
          end else begin
            take_link_nxt = r_link;
            state_nxt     = ST_ALLOC_TAKE;
          end
        end else if (r_nil) begin
          ok_nxt    = 1'b0;
          state_nxt = ST_STATS_START;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = r_link[AW-1:0];
          cur_nxt   = r_link[AW-1:0];
        end
      end

      // Lowest inactive descriptor takes the split-off tail
      ST_SPARE_SCAN: begin
        if (!r_flags[F_ACTIVE]) begin
          mem_we        = 1'b1;
          mem_waddr     = scan_r;
          mem_wdata     = pack(h_start_r + SW'(req_r.req_size), h_len_r - size_l,
                               FLAGS_ACTIVE, '0, h_link_r);
          take_link_nxt = IW'(scan_r);
          state_nxt     = ST_ALLOC_TAKE;
        end else if (scan_r == LAST) begin
          ok_nxt    = 1'b0;
          state_nxt = ST_STATS_START;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = scan_r + AW'(1);
          scan_nxt  = scan_r + AW'(1);
        end
      end

      ST_ALLOC_TAKE: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r;
        mem_wdata = pack(h_start_r, size_l, take_flags, next_id_r, take_link_r);
        off_nxt       = h_start_r;
        id_nxt        = next_id_r;
        next_id_nxt   = next_id_r + 32'd1;
        cnt_alloc_nxt = cnt_alloc_r + 32'd1;
        if (!req_r.persistent) begin
          cnt_salloc_nxt = cnt_salloc_r + 32'd1;
        end
        state_nxt = ST_STATS_START;
      end

      // Exact-offset lookup for a release
      ST_FREE_WALK: begin
        if (off_hit) begin
          mem_we       = 1'b1;
          mem_waddr    = cur_r;
          mem_wdata    = pack(r_start, r_len, FLAGS_ACTIVE, '0, r_link);
          cnt_free_nxt = cnt_free_r + 32'd1;
          if (!r_flags[F_PERSIST]) begin
            cnt_sfree_nxt = cnt_sfree_r + 32'd1;
          end
          state_nxt = ST_MERGE_START;
        end else if (r_nil) begin
          ok_nxt    = 1'b0;
          state_nxt = ST_STATS_START;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = r_link[AW-1:0];
          cur_nxt   = r_link[AW-1:0];
        end
      end

      // Release every session-owned segment
      ST_SESS_WALK: begin
        if (r_flags[F_USED] && !r_flags[F_PERSIST]) begin
          mem_we        = 1'b1;
          mem_waddr     = cur_r;
          mem_wdata     = pack(r_start, r_len, FLAGS_ACTIVE, '0, r_link);
          cnt_free_nxt  = cnt_free_r + 32'd1;
          cnt_sfree_nxt = cnt_sfree_r + 32'd1;
        end
        if (r_nil) begin
          cnt_salloc_nxt = '0;
          cnt_sfree_nxt  = '0;
          state_nxt      = ST_MERGE_START;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = r_link[AW-1:0];
          cur_nxt   = r_link[AW-1:0];
        end
      end

      ST_MERGE_START: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        cur_nxt   = '0;
        state_nxt = ST_MERGE_CUR;
      end

      // Current segment is held in registers; successors stream past it
      ST_MERGE_CUR: begin
        h_start_nxt = r_start;
        h_len_nxt   = r_len;
        h_flags_nxt = r_flags;
        h_id_nxt    = r_id;
        h_link_nxt  = r_link;
        if (r_nil) begin
          state_nxt = ST_STATS_START;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = r_link[AW-1:0];
          nx_nxt    = r_link[AW-1:0];
          state_nxt = ST_MERGE_NX;
        end
      end

      ST_MERGE_NX: begin
        mem_we = 1'b1;
        if (!h_flags_r[F_USED] && !r_flags[F_USED]) begin
          // absorb the successor and retire its descriptor
          mem_waddr  = nx_r;
          mem_wdata  = pack('0, '0, FLAGS_NONE, '0, NIL);
          h_len_nxt  = h_len_r + r_len;
          h_link_nxt = r_link;
          if (r_nil) begin
            state_nxt = ST_MERGE_FIN;
          end
        end else begin
          // write back the held segment and step on
          mem_waddr   = cur_r;
          mem_wdata   = pack(h_start_r, h_len_r, h_flags_r, h_id_r, h_link_r);
          cur_nxt     = nx_r;
          h_start_nxt = r_start;
          h_len_nxt   = r_len;
          h_flags_nxt = r_flags;
          h_id_nxt    = r_id;
          h_link_nxt  = r_link;
          if (r_nil) begin
            state_nxt = ST_STATS_START;
          end
        end
        if (!r_nil) begin
          mem_re    = 1'b1;
          mem_raddr = r_link[AW-1:0];
          nx_nxt    = r_link[AW-1:0];
        end
      end

      ST_MERGE_FIN: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r;
        mem_wdata = pack(h_start_r, h_len_r, h_flags_r, h_id_r, h_link_r);
        state_nxt = ST_STATS_START;
      end

      ST_STATS_START: begin
        mem_re     = 1'b1;
        mem_raddr  = '0;
        st_ctl.clr = 1'b1;
        state_nxt  = ST_STATS_WALK;
      end

      ST_STATS_WALK: begin
        st_ctl.en = 1'b1;
        if (r_nil) begin
          state_nxt = ST_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = r_link[AW-1:0];
        end
      end

      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.status             = !ok_r;
          out_nxt.alloc_offset       = 16'(off_r);
          out_nxt.alloc_id           = id_r;
          out_nxt.bytes_held         = 17'(st_used);
          out_nxt.largest_free       = 17'(st_big);
          out_nxt.free_segments      = 12'(st_nfree);
          out_nxt.active_allocs      = 12'(st_nused);
          out_nxt.session_bytes_held = 17'(st_sess);
          out_nxt.total_allocs       = cnt_alloc_r;
          out_nxt.total_frees        = cnt_free_r;
          out_nxt.session_allocs     = cnt_salloc_r;
          out_nxt.session_frees      = cnt_sfree_r;
          out_valid_nxt              = 1'b1;
          state_nxt                  = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
      next_id_r    <= 32'd1;
      cnt_alloc_r  <= '0;
      cnt_free_r   <= '0;
      cnt_salloc_r <= '0;
      cnt_sfree_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      out_valid_r  <= out_valid_nxt;
      next_id_r    <= next_id_nxt;
      cnt_alloc_r  <= cnt_alloc_nxt;
      cnt_free_r   <= cnt_free_nxt;
      cnt_salloc_r <= cnt_salloc_nxt;
      cnt_sfree_r  <= cnt_sfree_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    nx_r        <= nx_nxt;
    scan_r      <= scan_nxt;
    take_link_r <= take_link_nxt;
    h_start_r   <= h_start_nxt;
    h_len_r     <= h_len_nxt;
    h_flags_r   <= h_flags_nxt;
    h_id_r      <= h_id_nxt;
    h_link_r    <= h_link_nxt;
    req_r       <= req_nxt;
    ok_r        <= ok_nxt;
    off_r       <= off_nxt;
    id_r        <= id_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
